// ===== hdl/pff_pkg.sv =====
// ----------------------------------------------------------------------------
// pff_pkg
// Shared widths, codes, register defaults and beat types for the pair force
// kernel.
// ----------------------------------------------------------------------------
package pff_pkg;

  localparam int POS_W      = 24;   // Q10.14 position
  localparam int DISP_W     = 25;   // raw difference / folded displacement
  localparam int XABS_W     = 26;   // |2d + L|
  localparam int BOX_W      = 23;
  localparam int DIV2L_W    = 24;   // 2L
  localparam int R2_W       = 50;   // sum of squares, Q.28
  localparam int S_W        = 38;   // r2 >> 12
  localparam int ROOT_W     = 25;   // floor(sqrt(r2)), Q.14
  localparam int NUM_W      = 58;   // |v|*|d| << 8
  localparam int MUL_W      = 63;   // clamped product domain
  localparam int FORCE_W    = 32;
  localparam int K_W        = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] OP_REPULSION = 2'd0;
  localparam logic [1:0] OP_BOND      = 2'd1;
  localparam logic [1:0] OP_COHESIN   = 2'd2;

  localparam logic [1:0] ST_APPLIED   = 2'd0;
  localparam logic [1:0] ST_CUTOFF    = 2'd1;
  localparam logic [1:0] ST_ZERO_DIST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_LENGTH          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPULSION_CUTOFF    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOND_STIFFNESS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOND_REST_LENGTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COHESIN_STIFFNESS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COHESIN_REST_LENGTH = 3'd5;

  localparam logic [BOX_W-1:0] RST_BOX_LENGTH          = 23'd280320;
  localparam logic [BOX_W-1:0] RST_REPULSION_CUTOFF    = 23'd17203;
  localparam logic [K_W-1:0]   RST_BOND_STIFFNESS      = 32'd13107200;
  localparam logic [BOX_W-1:0] RST_BOND_REST_LENGTH    = 23'd16384;
  localparam logic [K_W-1:0]   RST_COHESIN_STIFFNESS   = 32'd3276800;
  localparam logic [BOX_W-1:0] RST_COHESIN_REST_LENGTH = 23'd8192;

  // repulsion polynomial coefficients, Q.24
  localparam logic [MUL_W-1:0] C14_Q24 = 63'd1067677902;
  localparam logic [MUL_W-1:0] C12_Q24 = 63'd1177114887;
  localparam logic [MUL_W-1:0] CLAMP62 = 63'h4000_0000_0000_0000;

  localparam int CMUL_LAT = 3;
  localparam int PIPE_LAT = 119;

  typedef struct packed {
    logic [1:0]              operation;
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [POS_W-1:0] first_z;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
    logic signed [POS_W-1:0] second_z;
  } in_item_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic signed [FORCE_W-1:0] force_z;
    logic [1:0]                status;
  } out_item_t;

endpackage

// ===== hdl/pff_delay.sv =====
// ----------------------------------------------------------------------------
// pff_delay
// Fixed-length shift line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module pff_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [N];

  always_ff @(posedge clk) begin
    taps[0] <= d;
    for (int i = 1; i < N; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign q = taps[N-1];

endmodule

// ===== hdl/pff_cmul.sv =====
// ----------------------------------------------------------------------------
// pff_cmul
// Three-stage clamped multiply: partial products, sum, then clamp at 2^62
// and right shift.
// ----------------------------------------------------------------------------
module pff_cmul #(
  parameter int SH = 16
) (
  input  logic                     clk,
  input  logic [pff_pkg::MUL_W-1:0] a,
  input  logic [pff_pkg::MUL_W-1:0] b,
  output logic [pff_pkg::MUL_W-1:0] p
);

  import pff_pkg::*;

  localparam int PW = 2 * MUL_W;

  logic [31:0]   al, bl;
  logic [30:0]   ah, bh;
  logic [63:0]   pp_ll;
  logic [62:0]   pp_lh, pp_hl;
  logic [61:0]   pp_hh;
  logic [PW-1:0] prod;

  assign {ah, al} = a;
  assign {bh, bl} = b;

  always_ff @(posedge clk) begin
    pp_ll <= 64'(al) * 64'(bl);
    pp_lh <= 63'(al) * 63'(bh);
    pp_hl <= 63'(ah) * 63'(bl);
    pp_hh <= 62'(ah) * 62'(bh);
    prod  <= PW'(pp_ll) + (PW'(pp_lh) << 32) + (PW'(pp_hl) << 32) + (PW'(pp_hh) << 64);
    p     <= (prod > PW'(CLAMP62)) ? CLAMP62 : MUL_W'(prod >> SH);
  end

endmodule

// ===== hdl/pff_udiv.sv =====
// ----------------------------------------------------------------------------
// pff_udiv
// Pipelined restoring divider, one quotient bit per stage; the divisor
// travels with its dividend.
// ----------------------------------------------------------------------------
module pff_udiv #(
  parameter int NW = 26,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] dv,
  output logic [NW-1:0] q,
  output logic [DW-1:0] r
);

  logic [NW-1:0] w_s   [NW];
  logic [DW-1:0] rem_s [NW];
  logic [DW-1:0] dv_s  [NW];
  logic [NW-1:0] w_i   [NW];
  logic [DW-1:0] rem_i [NW];
  logic [DW-1:0] dv_i  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign w_i[k]   = n;
      assign rem_i[k] = '0;
      assign dv_i[k]  = dv;
    end else begin : g_next
      assign w_i[k]   = w_s[k-1];
      assign rem_i[k] = rem_s[k-1];
      assign dv_i[k]  = dv_s[k-1];
    end

    assign trial = {rem_i[k], w_i[k][NW-1]};
    assign ge    = (trial >= {1'b0, dv_i[k]});

    always_ff @(posedge clk) begin
      rem_s[k] <= ge ? DW'(trial - {1'b0, dv_i[k]}) : DW'(trial);
      w_s[k]   <= {w_i[k][NW-2:0], ge};
      dv_s[k]  <= dv_i[k];
    end
  end

  assign q = w_s[NW-1];
  assign r = rem_s[NW-1];

endmodule

// ===== hdl/pff_isqrt.sv =====
// ----------------------------------------------------------------------------
// pff_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module pff_isqrt #(
  parameter int NW = 50,
  parameter int RW = 25
) (
  input  logic          clk,
  input  logic [NW-1:0] n,
  output logic [RW-1:0] root
);

  logic [NW-1:0] n_s   [RW];
  logic [NW:0]   res_s [RW];
  logic [NW-1:0] n_i   [RW];
  logic [NW:0]   res_i [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    localparam logic [NW:0] BITC = (NW+1)'(1) << (2 * (RW - 1 - k));
    logic [NW:0] sum;
    logic        ge;

    if (k == 0) begin : g_first
      assign n_i[k]   = n;
      assign res_i[k] = '0;
    end else begin : g_next
      assign n_i[k]   = n_s[k-1];
      assign res_i[k] = res_s[k-1];
    end

    assign sum = res_i[k] + BITC;
    assign ge  = ({1'b0, n_i[k]} >= sum);

    always_ff @(posedge clk) begin
      n_s[k]   <= ge ? NW'({1'b0, n_i[k]} - sum) : n_i[k];
      res_s[k] <= ge ? ((res_i[k] >> 1) + BITC) : (res_i[k] >> 1);
    end
  end

  assign root = res_s[RW-1][RW-1:0];

endmodule

// ===== hdl/polymer_pair_force_kernel_core.sv =====
// ----------------------------------------------------------------------------
// polymer_pair_force_kernel_core
// Pair force on the first particle of a pair: minimum-image displacement,
// soft repulsion or harmonic spring, saturated Q16.16 force.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: raise start with item; it is taken at any edge where busy
//   is low. busy never rises, so a pair can enter on every clock.
//   Output beat: done is high for one cycle with result. Results leave in
//   input order, one per pair; the receiver must take them as they come.
//   Throughput: one pair per clock. Latency is set by the spring branch:
//   the 26-step box fold divider, 25-step square root and 58-step
//   quotient divider, all fully pipelined; the repulsion branch is
//   padded to match.
//   Configuration: cfg_we writes cfg_data into register cfg_index at the
//   clock edge; unknown indexes are dropped. Write only while no pair is
//   in flight.
//   Reset (rst, synchronous): registers take their defaults and the
//   in-flight valid bits clear; pairs in flight are dropped.
// ----------------------------------------------------------------------------
module polymer_pair_force_kernel_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  pff_pkg::in_item_t              item,
  output logic                           done,
  output pff_pkg::out_item_t             result,
  input  logic                           cfg_we,
  input  logic [pff_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pff_pkg::CFG_DATA_W-1:0] cfg_data
);

  import pff_pkg::*;

  function automatic logic [FORCE_W-1:0] pack_force(input logic [MUL_W-1:0] mag,
                                                     input logic neg);
    logic [FORCE_W-1:0] res;
    if (neg) begin
      res = (mag >= 63'h8000_0000) ? 32'h8000_0000 : 32'(32'd0 - mag[31:0]);
    end else begin
      res = (mag > 63'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return res;
  endfunction

  // configuration registers
  logic [BOX_W-1:0]   box_length;
  logic [BOX_W-1:0]   repulsion_cutoff;
  logic [K_W-1:0]     bond_stiffness;
  logic [BOX_W-1:0]   bond_rest_length;
  logic [K_W-1:0]     cohesin_stiffness;
  logic [BOX_W-1:0]   cohesin_rest_length;
  logic [2*BOX_W-1:0] cutoff_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_length          <= RST_BOX_LENGTH;
      repulsion_cutoff    <= RST_REPULSION_CUTOFF;
      bond_stiffness      <= RST_BOND_STIFFNESS;
      bond_rest_length    <= RST_BOND_REST_LENGTH;
      cohesin_stiffness   <= RST_COHESIN_STIFFNESS;
      cohesin_rest_length <= RST_COHESIN_REST_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_LENGTH:          box_length          <= cfg_data[BOX_W-1:0];
        REG_REPULSION_CUTOFF:    repulsion_cutoff    <= cfg_data[BOX_W-1:0];
        REG_BOND_STIFFNESS:      bond_stiffness      <= cfg_data;
        REG_BOND_REST_LENGTH:    bond_rest_length    <= cfg_data[BOX_W-1:0];
        REG_COHESIN_STIFFNESS:   cohesin_stiffness   <= cfg_data;
        REG_COHESIN_REST_LENGTH: cohesin_rest_length <= cfg_data[BOX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cutoff_sq <= (2*BOX_W)'(repulsion_cutoff) * (2*BOX_W)'(repulsion_cutoff);
  end

  logic                accept;
  logic [PIPE_LAT-1:0] vld_pipe;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe <= '0;
    end else begin
      vld_pipe <= {vld_pipe[PIPE_LAT-2:0], accept};
    end
  end

  assign done = vld_pipe[PIPE_LAT-1];

  // stage 1: raw difference and 2d + L
  logic [2:0][POS_W-1:0]  first_p, second_p;
  logic [2:0][DISP_W-1:0] d_c;
  logic [2:0][XABS_W:0]   xs_c;
  logic [2:0][DISP_W-1:0] d1;
  logic [2:0]             xneg1;
  logic [2:0][XABS_W-1:0] xabs1;
  logic [1:0]             op1;

  assign first_p  = {item.first_z, item.first_y, item.first_x};
  assign second_p = {item.second_z, item.second_y, item.second_x};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d_c[j]  = {second_p[j][POS_W-1], second_p[j]} - {first_p[j][POS_W-1], first_p[j]};
      xs_c[j] = {d_c[j][DISP_W-1], d_c[j], 1'b0} + (XABS_W+1)'(box_length);
    end
  end

  always_ff @(posedge clk) begin
    op1 <= item.operation;
    for (int j = 0; j < 3; j++) begin
      d1[j]    <= d_c[j];
      xneg1[j] <= xs_c[j][XABS_W];
      xabs1[j] <= xs_c[j][XABS_W] ? XABS_W'(-xs_c[j]) : XABS_W'(xs_c[j]);
    end
  end

  // box fold remainder, stages 2..27
  logic [DIV2L_W-1:0]      two_l;
  logic [2:0][DIV2L_W-1:0] rem27;
  logic [2:0][DISP_W-1:0]  d27;
  logic [2:0]              xneg27;

  assign two_l = {box_length, 1'b0};

  for (genvar j = 0; j < 3; j++) begin : g_fold
    pff_udiv #(.NW(XABS_W), .DW(DIV2L_W)) u_fold (
      .clk (clk),
      .n   (xabs1[j]),
      .dv  (two_l),
      .q   (),
      .r   (rem27[j])
    );
  end

  pff_delay #(.W(3*DISP_W + 3), .N(XABS_W)) u_dly_d (
    .clk (clk),
    .d   ({d1, xneg1}),
    .q   ({d27, xneg27})
  );

  // stage 28: folded displacement
  logic [2:0][DISP_W-1:0] av28;
  logic [2:0]             vneg28;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      logic [DIV2L_W-1:0] m;
      logic [DISP_W-1:0]  t, vt, v;
      m  = (xneg27[j] && rem27[j] != '0) ? DIV2L_W'(two_l - rem27[j]) : rem27[j];
      t  = DISP_W'(m) - DISP_W'(box_length);
      vt = DISP_W'($signed(t + DISP_W'(t[DISP_W-1])) >>> 1);
      v  = (box_length == '0) ? d27[j] : vt;
      av28[j]   <= v[DISP_W-1] ? DISP_W'(-v) : v;
      vneg28[j] <= v[DISP_W-1];
    end
  end

  // stages 29, 30: squared length
  logic [2:0][R2_W-1:0] sq29;
  logic [R2_W-1:0]      r2_30;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      sq29[j] <= R2_W'(av28[j]) * R2_W'(av28[j]);
    end
    r2_30 <= sq29[0] + sq29[1] + sq29[2];
  end

  // side data
  logic [1:0]             op55, op115, op118;
  logic [2:0][DISP_W-1:0] av45, av56;
  logic [2:0]             vneg48, vneg118;

  pff_delay #(.W(2), .N(54)) u_dly_op55 (.clk(clk), .d(op1), .q(op55));
  pff_delay #(.W(2), .N(60)) u_dly_op115 (.clk(clk), .d(op55), .q(op115));
  pff_delay #(.W(2), .N(CMUL_LAT)) u_dly_op118 (.clk(clk), .d(op115), .q(op118));
  pff_delay #(.W(3*DISP_W), .N(17)) u_dly_av45 (.clk(clk), .d(av28), .q(av45));
  pff_delay #(.W(3*DISP_W), .N(11)) u_dly_av56 (.clk(clk), .d(av45), .q(av56));
  pff_delay #(.W(3), .N(20)) u_dly_vn48 (.clk(clk), .d(vneg28), .q(vneg48));
  pff_delay #(.W(3), .N(70)) u_dly_vn118 (.clk(clk), .d(vneg48), .q(vneg118));

  // repulsion branch
  logic [MUL_W-1:0] s30, s33, s36, s39;
  logic [MUL_W-1:0] p33, p36, p39, p42, g33, af42, t45;
  logic [MUL_W-1:0] af34;
  logic             fneg34, fneg48;
  logic             beyond31, beyond118;
  logic signed [MUL_W:0] f_c;

  assign s30 = MUL_W'(r2_30[R2_W-1:R2_W-S_W]);

  always_ff @(posedge clk) begin
    beyond31 <= (r2_30 >= R2_W'(cutoff_sq));
  end

  pff_delay #(.W(MUL_W), .N(CMUL_LAT)) u_dly_s33 (.clk(clk), .d(s30), .q(s33));
  pff_delay #(.W(MUL_W), .N(CMUL_LAT)) u_dly_s36 (.clk(clk), .d(s33), .q(s36));
  pff_delay #(.W(MUL_W), .N(CMUL_LAT)) u_dly_s39 (.clk(clk), .d(s36), .q(s39));
  pff_delay #(.W(1), .N(87)) u_dly_bey (.clk(clk), .d(beyond31), .q(beyond118));

  pff_cmul #(.SH(16)) u_p1 (.clk(clk), .a(s30), .b(s30), .p(p33));
  pff_cmul #(.SH(16)) u_p2 (.clk(clk), .a(p33), .b(s33), .p(p36));
  pff_cmul #(.SH(16)) u_p3 (.clk(clk), .a(p36), .b(s36), .p(p39));
  pff_cmul #(.SH(16)) u_p4 (.clk(clk), .a(p39), .b(s39), .p(p42));
  pff_cmul #(.SH(16)) u_g  (.clk(clk), .a(C14_Q24), .b(s30), .p(g33));

  assign f_c = $signed({1'b0, g33}) - $signed({1'b0, C12_Q24});

  always_ff @(posedge clk) begin
    af34   <= f_c[MUL_W] ? MUL_W'(-f_c) : MUL_W'(f_c);
    fneg34 <= f_c[MUL_W];
  end

  pff_delay #(.W(MUL_W), .N(8)) u_dly_af (.clk(clk), .d(af34), .q(af42));
  pff_delay #(.W(1), .N(14)) u_dly_fn (.clk(clk), .d(fneg34), .q(fneg48));

  pff_cmul #(.SH(24)) u_t (.clk(clk), .a(p42), .b(af42), .p(t45));

  logic [2:0][MUL_W-1:0] rmag48, rmag118;
  logic [2:0]            rsign48, rsign118;

  for (genvar j = 0; j < 3; j++) begin : g_rep
    pff_cmul #(.SH(14)) u_ax (
      .clk (clk),
      .a   (t45),
      .b   (MUL_W'(av45[j])),
      .p   (rmag48[j])
    );
    assign rsign48[j] = fneg48 ^ vneg48[j];
  end

  pff_delay #(.W(3*MUL_W + 3), .N(70)) u_dly_rep (
    .clk (clk),
    .d   ({rmag48, rsign48}),
    .q   ({rmag118, rsign118})
  );

  // spring branch
  logic [ROOT_W-1:0]      root55, root56, root57;
  logic [ROOT_W-1:0]      ad56;
  logic                   dneg56, dneg57, dneg118;
  logic                   rzero56, rzero57, rzero118;
  logic [2:0][R2_W-1:0]   num57;
  logic [2:0][NUM_W-1:0]  q115;
  logic [2:0][MUL_W-1:0]  smag118;
  logic [BOX_W-1:0]       rest_c;
  logic [ROOT_W:0]        dsp_c;
  logic [K_W-1:0]         k115;

  pff_isqrt #(.NW(R2_W), .RW(ROOT_W)) u_sqrt (.clk(clk), .n(r2_30), .root(root55));

  assign rest_c = (op55 == OP_BOND) ? bond_rest_length : cohesin_rest_length;
  assign dsp_c  = (ROOT_W+1)'(root55) - (ROOT_W+1)'(rest_c);

  always_ff @(posedge clk) begin
    ad56    <= dsp_c[ROOT_W] ? ROOT_W'(-dsp_c) : ROOT_W'(dsp_c);
    dneg56  <= dsp_c[ROOT_W];
    rzero56 <= (root55 == '0);
    root56  <= root55;
    for (int j = 0; j < 3; j++) begin
      num57[j] <= R2_W'(av56[j]) * R2_W'(ad56);
    end
    root57  <= root56;
    dneg57  <= dneg56;
    rzero57 <= rzero56;
  end

  pff_delay #(.W(2), .N(61)) u_dly_sp (
    .clk (clk),
    .d   ({dneg57, rzero57}),
    .q   ({dneg118, rzero118})
  );

  assign k115 = (op115 == OP_BOND) ? bond_stiffness : cohesin_stiffness;

  for (genvar j = 0; j < 3; j++) begin : g_spring
    pff_udiv #(.NW(NUM_W), .DW(ROOT_W)) u_qdiv (
      .clk (clk),
      .n   ({num57[j], 8'd0}),
      .dv  (root57),
      .q   (q115[j]),
      .r   ()
    );
    pff_cmul #(.SH(22)) u_k (
      .clk (clk),
      .a   (MUL_W'(k115)),
      .b   (MUL_W'(q115[j])),
      .p   (smag118[j])
    );
  end

  // output register
  out_item_t res_c;

  always_comb begin
    res_c        = '0;
    res_c.status = ST_CUTOFF;
    case (op118)
      OP_REPULSION: begin
        if (!beyond118) begin
          res_c.force_x = pack_force(rmag118[0], rsign118[0]);
          res_c.force_y = pack_force(rmag118[1], rsign118[1]);
          res_c.force_z = pack_force(rmag118[2], rsign118[2]);
          res_c.status  = ST_APPLIED;
        end
      end
      OP_BOND, OP_COHESIN: begin
        if (rzero118) begin
          res_c.status = ST_ZERO_DIST;
        end else begin
          res_c.force_x = pack_force(smag118[0], vneg118[0] ^ dneg118);
          res_c.force_y = pack_force(smag118[1], vneg118[1] ^ dneg118);
          res_c.force_z = pack_force(smag118[2], vneg118[2] ^ dneg118);
          res_c.status  = ST_APPLIED;
        end
      end
      default: res_c.status = ST_CUTOFF;
    endcase
  end

  always_ff @(posedge clk) begin
    result <= res_c;
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pair force kernel: a directed table of pairs
// and register settings, then random pairs under several box and spring
// settings, every beat compared with its typed force or an integer force predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import pff_pkg::*;

  localparam int N_RANDOM    = 1750;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    in_item_t  pair;
    bit        has_force;    // expected force typed in
    out_item_t force_val;
  } pair_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              item = '0;
  logic                  done;
  out_item_t             result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the registers
  longint unsigned box_len, cutoff, bond_k, bond_rest, coh_k, coh_rest;

  out_item_t force_queue[$];
  int        err_count = 0;
  int        cycle_count = 0;

  always #2 clk = ~clk;

  polymer_pair_force_kernel_core i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic longint unsigned clamp_mul(longint unsigned a,
                                               longint unsigned b, int sh);
    longint unsigned lim;
    longint unsigned prod;
    lim = 64'd1 << 62;
    if (a != 0 && b > lim / a) return lim;
    prod = (a * b) >> sh;
    return (prod > lim) ? lim : prod;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint min_image(longint d);
    longint len;
    longint m;
    len = longint'(box_len);
    if (len == 0) return d;
    m = (2 * d + len) % (2 * len);
    if (m < 0) m += 2 * len;
    return (m - len) / 2;
  endfunction

  function automatic logic [FORCE_W-1:0] sat_force(longint unsigned mag, bit neg);
    if (neg) begin
      if (mag >= 64'h8000_0000) return 32'h8000_0000;
      return 32'(64'h1_0000_0000 - mag);
    end
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(mag);
  endfunction

  function automatic out_item_t pair_force(in_item_t p);
    out_item_t       o;
    longint          v[3];
    longint unsigned av[3];
    longint unsigned r2, s, pw, g, t, k, rest, r, ad, q;
    longint          f, d;
    o = '0;
    r2 = 0;
    v[0] = min_image(longint'(p.second_x) - longint'(p.first_x));
    v[1] = min_image(longint'(p.second_y) - longint'(p.first_y));
    v[2] = min_image(longint'(p.second_z) - longint'(p.first_z));
    for (int j = 0; j < 3; j++) begin
      av[j] = (v[j] < 0) ? longint'(-v[j]) : v[j];
      r2 += av[j] * av[j];
    end
    if (p.operation == OP_REPULSION) begin
      if (r2 >= cutoff * cutoff) begin
        o.status = ST_CUTOFF;
        return o;
      end
      s = r2 >> 12;
      pw = s;
      for (int j = 0; j < 4; j++) pw = clamp_mul(pw, s, 16);
      g = clamp_mul(longint'(C14_Q24), s, 16);
      f = longint'(g) - longint'(C12_Q24);
      t = clamp_mul(pw, (f < 0) ? -f : f, 24);
      o.force_x = sat_force(clamp_mul(t, av[0], 14), (f < 0) != (v[0] < 0));
      o.force_y = sat_force(clamp_mul(t, av[1], 14), (f < 0) != (v[1] < 0));
      o.force_z = sat_force(clamp_mul(t, av[2], 14), (f < 0) != (v[2] < 0));
      o.status = ST_APPLIED;
    end else if (p.operation == OP_BOND || p.operation == OP_COHESIN) begin
      k = (p.operation == OP_BOND) ? bond_k : coh_k;
      rest = (p.operation == OP_BOND) ? bond_rest : coh_rest;
      r = int_sqrt(r2);
      if (r == 0) begin
        o.status = ST_ZERO_DIST;
        return o;
      end
      d = longint'(r) - longint'(rest);
      ad = (d < 0) ? -d : d;
      for (int j = 0; j < 3; j++) begin
        q = ((av[j] * ad) << 8) / r;
        if (j == 0) o.force_x = sat_force(clamp_mul(k, q, 22), (v[j] < 0) != (d < 0));
        if (j == 1) o.force_y = sat_force(clamp_mul(k, q, 22), (v[j] < 0) != (d < 0));
        if (j == 2) o.force_z = sat_force(clamp_mul(k, q, 22), (v[j] < 0) != (d < 0));
      end
      o.status = ST_APPLIED;
    end else begin
      o.status = ST_CUTOFF;
    end
    return o;
  endfunction

  // idle length after a beat: mostly none, some short, a few long
  function automatic int gap_len();
    int n;
    n = 0;
    if ($urandom_range(0, 3) == 0) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    end
    return n;
  endfunction

  // one pair beat; start stays high across back-to-back beats
  task automatic send_pair(in_item_t p, bit typed, out_item_t exp_val);
    out_item_t pred;
    int        gap;
    pred = pair_force(p);
    if (typed && pred != exp_val)
      $display("%0t table row disagrees with predictor: exp %h pred %h",
               $time, exp_val, pred);
    force_queue.insert(force_queue.size(), typed ? exp_val : pred);
    start <= 1'b1;
    item  <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    gap = gap_len();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (force_queue.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 10) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BOX_LENGTH:          box_len   = val & 64'h7F_FFFF;
      REG_REPULSION_CUTOFF:    cutoff    = val & 64'h7F_FFFF;
      REG_BOND_STIFFNESS:      bond_k    = val & 64'hFFFF_FFFF;
      REG_BOND_REST_LENGTH:    bond_rest = val & 64'h7F_FFFF;
      REG_COHESIN_STIFFNESS:   coh_k     = val & 64'hFFFF_FFFF;
      REG_COHESIN_REST_LENGTH: coh_rest  = val & 64'h7F_FFFF;
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic in_item_t mk(logic [1:0] op, int fx, int fy, int fz,
                                  int sx, int sy, int sz);
    in_item_t p;
    p.operation = op;
    p.first_x = 24'(fx); p.first_y = 24'(fy); p.first_z = 24'(fz);
    p.second_x = 24'(sx); p.second_y = 24'(sy); p.second_z = 24'(sz);
    return p;
  endfunction

  function automatic in_item_t random_pair();
    in_item_t p;
    int       spread;
    p.operation = 2'($urandom_range(0, 3));
    if (p.operation == 2'd3 && $urandom_range(0, 1)) p.operation = OP_BOND;
    p.first_x = 24'($urandom); p.first_y = 24'($urandom); p.first_z = 24'($urandom);
    case ($urandom_range(0, 3))
      0: begin
        p.second_x = 24'($urandom); p.second_y = 24'($urandom);
        p.second_z = 24'($urandom);
      end
      default: begin
        // close pairs, where repulsion and springs are live
        spread = (p.operation == OP_REPULSION) ? 12000 : 40000;
        p.second_x = p.first_x + 24'($urandom_range(0, 2 * spread) - spread);
        p.second_y = p.first_y + 24'($urandom_range(0, 2 * spread) - spread);
        p.second_z = p.first_z + 24'($urandom_range(0, 2 * spread) - spread);
      end
    endcase
    return p;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t exp_val;
    if (!rst && done) begin
      if (force_queue.size() == 0) begin
        $display("%0t unexpected beat: actual %h", $time, result);
        err_count++;
      end else begin
        exp_val = force_queue.pop_front();
        if (result.force_x !== exp_val.force_x) begin
          $display("%0t force_x exp %h act %h", $time, exp_val.force_x, result.force_x);
          err_count++;
        end
        if (result.force_y !== exp_val.force_y) begin
          $display("%0t force_y exp %h act %h", $time, exp_val.force_y, result.force_y);
          err_count++;
        end
        if (result.force_z !== exp_val.force_z) begin
          $display("%0t force_z exp %h act %h", $time, exp_val.force_z, result.force_z);
          err_count++;
        end
        if (result.status !== exp_val.status) begin
          $display("%0t status exp %0d act %0d", $time, exp_val.status, result.status);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    pair_row_t rows[$];
    pair_row_t row;
    out_item_t zero_force;
    longint unsigned box_set[5];
    box_len = RST_BOX_LENGTH;   cutoff = RST_REPULSION_CUTOFF;
    bond_k = RST_BOND_STIFFNESS; bond_rest = RST_BOND_REST_LENGTH;
    coh_k = RST_COHESIN_STIFFNESS; coh_rest = RST_COHESIN_REST_LENGTH;
    zero_force = '0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    row.has_force = 1'b1;
    row.force_val = zero_force; row.force_val.status = ST_ZERO_DIST;
    row.pair = mk(OP_BOND, 5, 5, 5, 5, 5, 5);            rows.insert(rows.size(), row);
    row.pair = mk(OP_COHESIN, -8388608, 0, 8388607, -8388608, 0, 8388607);
    rows.insert(rows.size(), row);
    row.force_val.status = ST_CUTOFF;
    row.pair = mk(OP_REPULSION, 0, 0, 0, 40000, 0, 0);   rows.insert(rows.size(), row);
    row.pair = mk(2'd3, 1, 2, 3, 400, 500, 600);          rows.insert(rows.size(), row);
    row.pair = mk(2'd3, -8388608, 8388607, -1, 8388607, -8388608, 0);
    rows.insert(rows.size(), row);
    // spring exactly at rest length gives zero force, applied
    row.force_val.status = ST_APPLIED;
    row.pair = mk(OP_BOND, 0, 0, 0, 16384, 0, 0);         rows.insert(rows.size(), row);
    row.pair = mk(OP_COHESIN, 100, 0, 0, 100, -8192, 0);  rows.insert(rows.size(), row);
    row.has_force = 1'b0;
    row.pair = mk(OP_REPULSION, 0, 0, 0, 0, 0, 0);        rows.insert(rows.size(), row);
    row.pair = mk(OP_REPULSION, 0, 0, 0, 17202, 0, 0);    rows.insert(rows.size(), row);
    row.pair = mk(OP_REPULSION, 10, 10, 10, 5000, -3000, 2000);
    rows.insert(rows.size(), row);
    row.pair = mk(OP_REPULSION, 0, 0, 0, 0, 0, 1);        rows.insert(rows.size(), row);
    row.pair = mk(OP_BOND, 0, 0, 0, 1, 0, 0);             rows.insert(rows.size(), row);
    row.pair = mk(OP_BOND, 0, 0, 0, 140159, 140159, -140160);
    rows.insert(rows.size(), row);
    row.pair = mk(OP_BOND, 8388607, 8388607, 8388607, -8388608, -8388608, -8388608);
    rows.insert(rows.size(), row);
    row.pair = mk(OP_COHESIN, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607);
    rows.insert(rows.size(), row);
    row.pair = mk(OP_COHESIN, 0, 0, 0, 30000, -20000, 10000);
    rows.insert(rows.size(), row);
    foreach (rows[i]) send_pair(rows[i].pair, rows[i].has_force, rows[i].force_val);
    drain();

    // extremes of the registers, incl. no folding and saturating springs
    write_reg(REG_BOX_LENGTH, 0);
    write_reg(REG_REPULSION_CUTOFF, 64'h7F_FFFF);
    write_reg(REG_BOND_STIFFNESS, 64'hFFFF_FFFF);
    write_reg(REG_BOND_REST_LENGTH, 0);
    write_reg(REG_COHESIN_STIFFNESS, 0);
    write_reg(REG_COHESIN_REST_LENGTH, 64'h7F_FFFF);
    write_reg(3'd7, 64'h1234);   // unknown index, dropped
    send_pair(mk(OP_BOND, -8388608, 0, 0, 8388607, 0, 0), 1'b0, zero_force);
    send_pair(mk(OP_COHESIN, 0, 0, 0, 3, 4, 0), 1'b0, zero_force);
    send_pair(mk(OP_REPULSION, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607),
              1'b0, zero_force);
    send_pair(mk(OP_REPULSION, 0, 0, 0, 20000, 20000, 0), 1'b0, zero_force);
    drain();

    // random phases, each under its own setting
    box_set = '{64'd1, 64'd280320, 64'h7F_FFFF, 64'd0, 64'd65536};
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_BOX_LENGTH, box_set[ph]);
      write_reg(REG_REPULSION_CUTOFF, (ph == 1) ? 0 : $urandom_range(8000, 30000));
      write_reg(REG_BOND_STIFFNESS, (ph == 2) ? 64'hFFFF_FFFF : $urandom_range(0, 30000000));
      write_reg(REG_BOND_REST_LENGTH, $urandom_range(0, 40000));
      write_reg(REG_COHESIN_STIFFNESS, $urandom);
      write_reg(REG_COHESIN_REST_LENGTH, (ph == 4) ? 64'h7F_FFFF : $urandom_range(0, 40000));
      for (int i = 0; i < N_RANDOM / 5; i++) send_pair(random_pair(), 1'b0, zero_force);
      drain();
    end

    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
